// ----- rtl/core/cdq_pkg.sv -----
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and codes of the circular deque.
// ----------------------------------------------------------------------------
package cdq_pkg;

   localparam int DEPTH_DEFAULT = 64;
   localparam int ACTION_W      = 2;
   localparam int WORD_W        = 32;
   localparam int STATUS_W      = 2;
   localparam int COUNT_OUT_W   = 7;

   localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_PUSH_REAR  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_POP_REAR   = 2'd3;

   localparam logic [STATUS_W-1:0] STS_DONE      = 2'd0;
   localparam logic [STATUS_W-1:0] STS_OVERFLOW  = 2'd1;
   localparam logic [STATUS_W-1:0] STS_UNDERFLOW = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_LOAD,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic take_req;
      logic exec;
      logic finish;
   } cmd_type;

endpackage

// ----- rtl/core/cdq_ctrl.sv -----
// ----------------------------------------------------------------------------
// cdq_ctrl
// Sequencer of the deque: take a word, run it, load the result, hand it out.
// ----------------------------------------------------------------------------
module cdq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cdq_pkg::cmd_type  cmd
);

   cdq_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cdq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cdq_pkg::ST_IDLE: begin
            if (req_valid) state_in = cdq_pkg::ST_EXEC;
         end
         cdq_pkg::ST_EXEC: begin
            state_in = cdq_pkg::ST_LOAD;
         end
         cdq_pkg::ST_LOAD: begin
            state_in = cdq_pkg::ST_RESP;
         end
         cdq_pkg::ST_RESP: begin
            if (rsp_ready) state_in = cdq_pkg::ST_IDLE;
         end
         default: begin
            state_in = cdq_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      rsp_valid    = 1'b0;
      cmd.take_req = 1'b0;
      cmd.exec     = 1'b0;
      cmd.finish   = 1'b0;
      case (state_ff)
         cdq_pkg::ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.take_req = req_valid;
         end
         cdq_pkg::ST_EXEC: begin
            cmd.exec = 1'b1;
         end
         cdq_pkg::ST_LOAD: begin
            cmd.finish = 1'b1;
         end
         cdq_pkg::ST_RESP: begin
            rsp_valid = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request and response handshakes open together");

   a_accept_runs: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> cmd.exec)
      else $error("accepted word not executed next cycle");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |=> cmd.finish ##1 rsp_valid)
      else $error("result not presented after execution");

endmodule

// ----- rtl/core/cdq_datapath.sv -----
// ----------------------------------------------------------------------------
// cdq_datapath
// Circular store, front/rear indices, entry count and result registers.
// ----------------------------------------------------------------------------
module cdq_datapath #(
   parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  cdq_pkg::cmd_type                      cmd,
   input  logic [cdq_pkg::ACTION_W-1:0]          req_action,
   input  logic signed [cdq_pkg::WORD_W-1:0]     req_value,
   output logic [cdq_pkg::STATUS_W-1:0]          rsp_status,
   output logic signed [cdq_pkg::WORD_W-1:0]     rsp_popped_value,
   output logic [cdq_pkg::COUNT_OUT_W-1:0]       rsp_entry_count
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [cdq_pkg::WORD_W-1:0] store [DEPTH];

   logic [cdq_pkg::ACTION_W-1:0]   act_ff;
   logic [cdq_pkg::WORD_W-1:0]     val_ff;
   logic [IDX_W-1:0]               head_ff, head_in;
   logic [IDX_W-1:0]               tail_ff, tail_in;
   logic [CNT_W-1:0]               cnt_ff, cnt_in;
   logic [cdq_pkg::STATUS_W-1:0]   sts_ff, sts_in;
   logic                           pop_ok_ff, pop_ok_in;
   logic [cdq_pkg::WORD_W-1:0]     rd_ff;
   logic [cdq_pkg::STATUS_W-1:0]   rsp_sts_ff;
   logic [cdq_pkg::WORD_W-1:0]     rsp_pop_ff;
   logic [CNT_W-1:0]               rsp_cnt_ff;
   logic [CNT_W+cdq_pkg::COUNT_OUT_W-1:0] cnt_ext;

   logic                           wr_en;
   logic [IDX_W-1:0]               wr_addr;
   logic [IDX_W-1:0]               rd_addr;
   logic                           is_push, is_front;

   function automatic logic [IDX_W-1:0] step_up(input logic [IDX_W-1:0] i);
      return (i == IDX_LAST) ? '0 : i + IDX_W'(1);
   endfunction

   function automatic logic [IDX_W-1:0] step_down(input logic [IDX_W-1:0] i);
      return (i == '0) ? IDX_LAST : i - IDX_W'(1);
   endfunction

   always_comb begin
      is_push   = (act_ff == cdq_pkg::ACT_PUSH_FRONT) || (act_ff == cdq_pkg::ACT_PUSH_REAR);
      is_front  = (act_ff == cdq_pkg::ACT_PUSH_FRONT) || (act_ff == cdq_pkg::ACT_POP_FRONT);
      head_in   = head_ff;
      tail_in   = tail_ff;
      cnt_in    = cnt_ff;
      sts_in    = cdq_pkg::STS_DONE;
      pop_ok_in = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = '0;
      rd_addr   = is_front ? head_ff : tail_ff;
      if (is_push) begin
         if (cnt_ff >= CNT_FULL) begin
            sts_in = cdq_pkg::STS_OVERFLOW;
         end else begin
            wr_en  = 1'b1;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == '0) begin
               head_in = '0;
               tail_in = '0;
               wr_addr = '0;
            end else if (is_front) begin
               head_in = step_down(head_ff);
               wr_addr = head_in;
            end else begin
               tail_in = step_up(tail_ff);
               wr_addr = tail_in;
            end
         end
      end else begin
         if (cnt_ff == '0) begin
            sts_in = cdq_pkg::STS_UNDERFLOW;
         end else begin
            pop_ok_in = 1'b1;
            cnt_in    = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               head_in = '0;
               tail_in = '0;
            end else if (is_front) begin
               head_in = step_up(head_ff);
            end else begin
               tail_in = step_down(tail_ff);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && wr_en) store[wr_addr] <= val_ff;
      if (cmd.exec) rd_ff <= store[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.take_req) begin
         act_ff <= req_action;
         val_ff <= req_value;
      end
      if (cmd.exec) begin
         sts_ff    <= sts_in;
         pop_ok_ff <= pop_ok_in;
      end
      if (cmd.finish) begin
         rsp_sts_ff <= sts_ff;
         rsp_pop_ff <= pop_ok_ff ? rd_ff : '0;
         rsp_cnt_ff <= cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         cnt_ff  <= '0;
      end else if (cmd.exec) begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         cnt_ff  <= cnt_in;
      end
   end

   assign cnt_ext          = {{cdq_pkg::COUNT_OUT_W{1'b0}}, rsp_cnt_ff};
   assign rsp_status       = rsp_sts_ff;
   assign rsp_popped_value = rsp_pop_ff;
   assign rsp_entry_count  = cnt_ext[cdq_pkg::COUNT_OUT_W-1:0];

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_FULL)
      else $error("entry count above depth");

   a_empty_home: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0) |-> (head_ff == '0 && tail_ff == '0))
      else $error("indices not home while empty");

   a_full_no_write: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && cnt_ff == CNT_FULL) |-> !wr_en)
      else $error("write into full store");

endmodule

// ----- rtl/core/circular_deque.sv -----
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended queue kept in a circular store of DEPTH 32-bit words.
// ----------------------------------------------------------------------------
// Request channel (req_valid/req_ready): one word carries an action (push
// front, push rear, pop front, pop rear) and a value used by pushes.
// Response channel (rsp_valid/rsp_ready): one word per request with status
// (done, overflow, underflow), the popped value (zero unless a pop
// succeeded) and the entry count after the request (low 7 bits).
// An accepted request passes through the execute and load states before
// its response is valid; the store read is registered. One request is in
// flight at a time, and req_ready stays low until the response is taken.
// Reset (synchronous, active high) empties the deque and returns both
// indices to entry 0; store contents are not cleared and need no sweep.
// A stalled receiver simply holds the response register and the block.
// ----------------------------------------------------------------------------
module circular_deque #(
   parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [cdq_pkg::ACTION_W-1:0]          req_action,
   input  logic signed [cdq_pkg::WORD_W-1:0]     req_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [cdq_pkg::STATUS_W-1:0]          rsp_status,
   output logic signed [cdq_pkg::WORD_W-1:0]     rsp_popped_value,
   output logic [cdq_pkg::COUNT_OUT_W-1:0]       rsp_entry_count
);

   cdq_pkg::cmd_type cmd;

   cdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   cdq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_action       (req_action),
      .req_value        (req_value),
      .rsp_status       (rsp_status),
      .rsp_popped_value (rsp_popped_value),
      .rsp_entry_count  (rsp_entry_count)
   );

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking regression for the circular deque.
// ----------------------------------------------------------------------------
// A short directed run covers the underflow on either end, pushes into an
// empty deque, wrap of the front index and popping the last entry. Random
// stretches that lean toward filling, toward draining or toward a plain mix
// follow. They drive the deque through full (overflow) and empty
// (underflow) many times with random data. Every accepted request word is
// run through a behavioral deque, and each response word is checked field
// by field against the oldest prediction. Both handshakes idle in random
// bursts. The receiver once holds off for a long stretch while requests
// keep coming.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int DEPTH        = cdq_pkg::DEPTH_DEFAULT;
   localparam int RANDOM_ITEMS = 1730;
   localparam int TAIL_ITEMS   = 150;
   localparam int HOLD_AT      = 400;
   localparam int HOLD_CYCLES  = 300;

   typedef struct packed {
      logic [cdq_pkg::ACTION_W-1:0]        action;
      logic signed [cdq_pkg::WORD_W-1:0]   value;
   } deque_req_type;

   typedef struct packed {
      logic [cdq_pkg::STATUS_W-1:0]        status;
      logic signed [cdq_pkg::WORD_W-1:0]   popped;
      logic [cdq_pkg::COUNT_OUT_W-1:0]     entries;
   } deque_rsp_type;

   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_NOISE} mix_kind_type;

   logic                                  clock = 1'b0;
   logic                                  reset = 1'b1;
   logic                                  req_valid = 1'b0;
   logic                                  req_ready;
   logic [cdq_pkg::ACTION_W-1:0]          req_action = cdq_pkg::ACT_PUSH_FRONT;
   logic signed [cdq_pkg::WORD_W-1:0]     req_value = '0;
   logic                                  rsp_valid;
   logic                                  rsp_ready = 1'b0;
   logic [cdq_pkg::STATUS_W-1:0]          rsp_status;
   logic signed [cdq_pkg::WORD_W-1:0]     rsp_popped_value;
   logic [cdq_pkg::COUNT_OUT_W-1:0]       rsp_entry_count;

   deque_req_type request_q[$];
   deque_rsp_type expected_rsp_q[$];

   // behavioral deque
   logic [cdq_pkg::WORD_W-1:0] dq_mem [DEPTH];
   int dq_head = 0;
   int dq_tail = 0;
   int dq_fill = 0;

   int send_gap    = 0;
   int stall_left  = 0;
   int hold_left   = 0;
   bit hold_done   = 1'b0;
   int n_accepted  = 0;
   int n_responses = 0;
   int n_errors    = 0;
   int n_overflow  = 0;
   int n_underflow = 0;
   int n_popped    = 0;
   int peak_fill   = 0;

   circular_deque #(.DEPTH(DEPTH)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_popped_value (rsp_popped_value),
      .rsp_entry_count  (rsp_entry_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic deque_rsp_type deque_apply(
         input logic [cdq_pkg::ACTION_W-1:0] act,
         input logic [cdq_pkg::WORD_W-1:0] word);
      deque_rsp_type r;
      r.status = cdq_pkg::STS_DONE;
      r.popped = '0;
      if (act == cdq_pkg::ACT_PUSH_FRONT || act == cdq_pkg::ACT_PUSH_REAR) begin
         if (dq_fill >= DEPTH) begin
            r.status = cdq_pkg::STS_OVERFLOW;
         end else begin
            if (dq_fill == 0) begin
               dq_head = 0;
               dq_tail = 0;
            end else if (act == cdq_pkg::ACT_PUSH_FRONT) begin
               dq_head = (dq_head == 0) ? DEPTH - 1 : dq_head - 1;
            end else begin
               dq_tail = (dq_tail == DEPTH - 1) ? 0 : dq_tail + 1;
            end
            dq_mem[(act == cdq_pkg::ACT_PUSH_FRONT) ? dq_head : dq_tail] = word;
            dq_fill++;
         end
      end else begin
         if (dq_fill == 0) begin
            r.status = cdq_pkg::STS_UNDERFLOW;
         end else begin
            r.popped = dq_mem[(act == cdq_pkg::ACT_POP_FRONT) ? dq_head : dq_tail];
            if (dq_fill == 1) begin
               dq_head = 0;
               dq_tail = 0;
            end else if (act == cdq_pkg::ACT_POP_FRONT) begin
               dq_head = (dq_head == DEPTH - 1) ? 0 : dq_head + 1;
            end else begin
               dq_tail = (dq_tail == 0) ? DEPTH - 1 : dq_tail - 1;
            end
            dq_fill--;
         end
      end
      r.entries = dq_fill[cdq_pkg::COUNT_OUT_W-1:0];
      return r;
   endfunction

   function automatic logic [cdq_pkg::ACTION_W-1:0] pick_action(input bit is_push);
      if (is_push)
         return ($urandom_range(0, 1) != 0) ? cdq_pkg::ACT_PUSH_REAR : cdq_pkg::ACT_PUSH_FRONT;
      return ($urandom_range(0, 1) != 0) ? cdq_pkg::ACT_POP_REAR : cdq_pkg::ACT_POP_FRONT;
   endfunction

   function automatic logic [cdq_pkg::WORD_W-1:0] pick_word();
      case ($urandom_range(0, 15))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   task automatic add_request(input logic [cdq_pkg::ACTION_W-1:0] act,
                              input logic [cdq_pkg::WORD_W-1:0] word);
      deque_req_type item;
      item.action = act;
      item.value  = word;
      request_q.push_back(item);
   endtask

   // request driver
   always @(posedge clock) begin : drive_proc
      deque_req_type item;
      deque_rsp_type want;
      logic          offer;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  = 0;
      end else begin
         offer = req_valid;
         if (req_valid && req_ready) begin
            want = deque_apply(req_action, req_value);
            expected_rsp_q.push_back(want);
            n_accepted++;
            if (want.status == cdq_pkg::STS_OVERFLOW) n_overflow++;
            if (want.status == cdq_pkg::STS_UNDERFLOW) n_underflow++;
            if (want.status == cdq_pkg::STS_DONE &&
                (req_action == cdq_pkg::ACT_POP_FRONT ||
                 req_action == cdq_pkg::ACT_POP_REAR)) n_popped++;
            if (dq_fill > peak_fill) peak_fill = dq_fill;
            offer = 1'b0;
         end
         if (!offer) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (request_q.size() > 0) begin
               if (request_q.size() > TAIL_ITEMS && $urandom_range(0, 9) == 0) begin
                  send_gap = $urandom_range(0, 18);
               end else begin
                  item = request_q.pop_front();
                  req_action <= item.action;
                  req_value  <= item.value;
                  offer = 1'b1;
               end
            end
         end
         req_valid <= offer;
      end
   end

   // response monitor and checker
   always @(posedge clock) begin : check_proc
      deque_rsp_type want;
      logic          take;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            n_responses++;
            if (expected_rsp_q.size() == 0) begin
               $display("%0t: unexpected response word: expected none, actual status=%0d",
                        $time, rsp_status);
               n_errors++;
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_status !== want.status) begin
                  $display("%0t: status mismatch: expected %0d, actual %0d",
                           $time, want.status, rsp_status);
                  n_errors++;
               end
               if (rsp_popped_value !== want.popped) begin
                  $display("%0t: popped_value mismatch: expected %0d, actual %0d",
                           $time, want.popped, rsp_popped_value);
                  n_errors++;
               end
               if (rsp_entry_count !== want.entries) begin
                  $display("%0t: entry_count mismatch: expected %0d, actual %0d",
                           $time, want.entries, rsp_entry_count);
                  n_errors++;
               end
            end
         end
         take = 1'b1;
         if (hold_left > 0) begin
            hold_left--;
            take = 1'b0;
         end else if (!hold_done && n_responses == HOLD_AT) begin
            // hold off long enough that the sender stalls
            hold_left = HOLD_CYCLES - 1;
            hold_done = 1'b1;
            take = 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            take = 1'b0;
         end else if (request_q.size() > TAIL_ITEMS && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 18);
            take = 1'b0;
         end
         rsp_ready <= take;
      end
   end

   initial begin : stimulus
      mix_kind_type mix;
      int           span;
      int           roll;
      int           made;
      bit           is_push;

      // underflow on either end, then single-entry push and pop
      add_request(cdq_pkg::ACT_POP_FRONT, 32'h1234_5678);
      add_request(cdq_pkg::ACT_POP_REAR, 32'hFFFF_FFFF);
      add_request(cdq_pkg::ACT_PUSH_FRONT, 32'h7FFF_FFFF);
      add_request(cdq_pkg::ACT_POP_REAR, 32'h0);
      add_request(cdq_pkg::ACT_PUSH_REAR, 32'h8000_0000);
      add_request(cdq_pkg::ACT_POP_FRONT, 32'h0);
      add_request(cdq_pkg::ACT_POP_FRONT, 32'h0);
      // wrap the front index below entry 0, then drain from both ends
      add_request(cdq_pkg::ACT_PUSH_REAR, 32'h8000_0000);
      add_request(cdq_pkg::ACT_PUSH_FRONT, 32'hFFFF_FFFF);
      add_request(cdq_pkg::ACT_PUSH_FRONT, 32'h0000_0000);
      add_request(cdq_pkg::ACT_PUSH_REAR, 32'h7FFF_FFFF);
      add_request(cdq_pkg::ACT_PUSH_FRONT, 32'h0000_0001);
      add_request(cdq_pkg::ACT_POP_FRONT, 32'h0);
      add_request(cdq_pkg::ACT_POP_REAR, 32'h0);
      add_request(cdq_pkg::ACT_POP_FRONT, 32'h0);
      add_request(cdq_pkg::ACT_POP_REAR, 32'h0);
      add_request(cdq_pkg::ACT_POP_FRONT, 32'h0);
      add_request(cdq_pkg::ACT_POP_REAR, 32'h0);
      add_request(cdq_pkg::ACT_PUSH_REAR, 32'hA5A5_5A5A);
      add_request(cdq_pkg::ACT_POP_FRONT, 32'h0);

      made = 0;
      while (made < RANDOM_ITEMS) begin
         mix  = mix_kind_type'($urandom_range(0, 2));
         span = $urandom_range(70, 130);
         for (int k = 0; k < span && made < RANDOM_ITEMS; k++) begin
            roll = $urandom_range(0, 99);
            case (mix)
               MIX_FILL:  is_push = (roll < 88);
               MIX_DRAIN: is_push = (roll < 12);
               default:   is_push = (roll < 50);
            endcase
            add_request(pick_action(is_push), pick_word());
            made++;
         end
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      while (request_q.size() != 0 || req_valid || expected_rsp_q.size() != 0)
         @(negedge clock);
      repeat (10) @(posedge clock);

      $display("covered %0d request words: %0d overflows, %0d underflows, %0d pops",
               n_accepted, n_overflow, n_underflow, n_popped);
      $display("deepest fill %0d of %0d entries, %0d response words checked, %0d errors",
               peak_fill, DEPTH, n_responses, n_errors);
      if (n_errors == 0)
         $display("circular_deque regression: pass");
      else
         $display("circular_deque regression: fail");
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("circular_deque regression: fail");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/cdq_pkg.sv
rtl/core/cdq_ctrl.sv
rtl/core/cdq_datapath.sv
rtl/core/circular_deque.sv
tb/sv/tb_top.sv
